[src/edfc_pkg.sv]
package edfc_pkg;

  typedef enum logic [1:0] {
    OP_X2D = 2'd0,
    OP_D2X = 2'd1,
    OP_PC  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [1:0] PC_SINGLE = 2'd0;
  localparam logic [1:0] PC_EXT    = 2'd3;

  localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;
  localparam logic [63:0] DBL_QNAN = 64'h7FF8000000000000;
  localparam logic [10:0] DBL_EXP_MAX = 11'd2047;
  localparam int EXT_BIAS = 16383;
  localparam int DBL_BIAS = 1023;

  // per-stage control travelling with the word
  typedef struct packed {
    logic       vld;
    op_t        op;
    logic [1:0] mode;
  } ctl_t;

  function automatic logic [63:0] ext_to_dbl(input logic [63:0] lo, input logic [15:0] hi);
    logic [63:0] sgn;
    logic [14:0] e;
    logic signed [16:0] adj;
    begin
      sgn = {hi[15], 63'd0};
      e = hi[14:0];
      adj = $signed({2'b00, e}) - 17'sd16383 + 17'sd1023;
      if (e == EXT_EXP_MAX) begin
        ext_to_dbl = (lo[62:0] != 63'd0) ? DBL_QNAN : (sgn | {1'b0, DBL_EXP_MAX, 52'd0});
      end else if (e == 15'd0 && lo == 64'd0) begin
        ext_to_dbl = sgn;
      end else if (adj <= 17'sd0) begin
        ext_to_dbl = sgn;
      end else if (adj >= 17'sd2047) begin
        ext_to_dbl = sgn | {1'b0, DBL_EXP_MAX, 52'd0};
      end else begin
        ext_to_dbl = {hi[15], adj[10:0], lo[62:11]};
      end
    end
  endfunction

  function automatic logic [79:0] dbl_to_ext(input logic [63:0] b);
    logic [10:0] e;
    logic [51:0] f;
    logic [14:0] xe;
    begin
      e = b[62:52];
      f = b[51:0];
      xe = 15'({4'd0, e} + 15'd15360);
      if (e == 11'h7FF) begin
        dbl_to_ext = (f != 52'd0) ? {16'h7FFF, 64'd1} : {b[63], EXT_EXP_MAX, 64'd0};
      end else if (e == 11'd0) begin
        dbl_to_ext = {b[63], 15'd0, 1'b0, f, 11'd0};
      end else begin
        dbl_to_ext = {b[63], xe, 1'b1, f, 11'd0};
      end
    end
  endfunction

endpackage

[src/edfc_round.sv]
// single-precision rounding of double bits, split over two register stages
module edfc_round (
  input  logic        clk,
  input  logic        en_a,
  input  logic        en_b,
  input  logic [63:0] din,
  output logic [63:0] dout
);
  import edfc_pkg::*;

  // stage a: shift out the dropped bits and decide the increment
  logic        a_sgn;
  logic        a_pass;
  logic        a_zero;
  logic        a_inf;
  logic [24:0] a_q;
  logic        a_inc;
  logic signed [12:0] a_ue;
  logic [5:0]  a_d;

  logic [10:0] e;
  logic signed [12:0] ue;
  logic signed [12:0] p;
  logic [5:0]  d;
  logic [52:0] m;
  logic [52:0] q;
  logic [52:0] rem;
  logic [52:0] half;
  logic [52:0] dmask;

  always_comb begin
    e = din[62:52];
    ue = $signed({2'b00, e}) - 13'sd1023;
    p = (ue >= -13'sd126) ? 13'sd24 : ue + 13'sd150;
    d = (p < 13'sd0 || p > 13'sd24) ? 6'd53 : 6'(13'sd53 - p);
    m = {1'b1, din[51:0]};
    q = m >> d;
    dmask = (53'd1 << d) - 53'd1;
    rem = m & dmask;
    half = 53'd1 << (d - 6'd1);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_sgn <= din[63];
      a_pass <= (e == 11'h7FF);
      a_zero <= (e == 11'd0) || (p < 13'sd0);
      a_inf <= (e != 11'h7FF) && (ue > 13'sd127);
      a_q <= q[24:0];
      a_inc <= (rem > half) || (rem == half && q[0]);
      a_ue <= ue;
      a_d <= d;
    end
  end

  // hold the nan/inf pattern for pass-through
  logic [63:0] a_raw;
  always_ff @(posedge clk) begin
    if (en_a) a_raw <= din;
  end

  // stage b: increment, find the leading one, renormalise
  logic [25:0] qi;
  logic [4:0]  lead;
  logic signed [12:0] ne;
  logic [63:0] res;

  always_comb begin
    qi = {1'b0, a_q} + {25'd0, a_inc};
    lead = 5'd0;
    for (int i = 1; i < 26; i++) begin
      if (qi[i]) lead = 5'(i);
    end
    ne = a_ue - 13'sd52 + $signed({7'd0, a_d}) + $signed({8'd0, lead});
    if (a_pass) begin
      res = a_raw;
    end else if (a_zero) begin
      res = {a_sgn, 63'd0};
    end else if (a_inf) begin
      res = {a_sgn, DBL_EXP_MAX, 52'd0};
    end else if (qi == 26'd0) begin
      res = {a_sgn, 63'd0};
    end else if (ne > 13'sd127) begin
      res = {a_sgn, DBL_EXP_MAX, 52'd0};
    end else begin
      res = {a_sgn, 11'(ne + 13'sd1023), 52'(({26'd0, qi} << (6'd52 - {1'b0, lead})))};
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) dout <= res;
  end
endmodule

[src/extended_double_format_converter.sv]
// Converts between x87 80-bit extended and IEEE double (op 0 extended to double,
// op 1 double to extended, op 2 precision control by precision_mode). Four register
// stages: input to double, single rounding in two steps, back to extended and the
// output register. One word is accepted every cycle unless the output register holds a
// word that ready_out has not taken. Register precision_mode sits at APB address 0.
module extended_double_format_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        ready_in,
  input  logic [1:0]  op,
  input  logic [63:0] value_low,
  input  logic [15:0] value_high,
  output logic        valid_out,
  input  logic        ready_out,
  output logic [63:0] result_low,
  output logic [15:0] result_high,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import edfc_pkg::*;

  logic [1:0] precision_mode;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, precision_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) precision_mode <= PC_EXT;
    else if (psel && penable && pwrite && paddr == 2'd0) precision_mode <= pwdata[1:0];
  end

  ctl_t c1, c2, c3, c4;
  logic adv;
  assign adv = !c4.vld || ready_out;
  assign ready_in = adv;
  assign valid_out = c4.vld;

  // stage 1
  logic [63:0] s1_dbl, s1_lo;
  logic [15:0] s1_hi;
  always_ff @(posedge clk) begin
    if (rst) c1 <= '0;
    else if (adv) c1 <= '{vld: valid_in, op: op_t'(op), mode: precision_mode};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dbl <= (op_t'(op) == OP_D2X) ? value_low : ext_to_dbl(value_low, value_high);
      s1_lo <= value_low;
      s1_hi <= value_high;
    end
  end

  // stages 2 and 3: rounding unit
  logic [63:0] s3_rnd, s2_dbl, s3_dbl, s2_lo, s3_lo;
  logic [15:0] s2_hi, s3_hi;
  edfc_round u_round (
    .clk(clk), .en_a(adv), .en_b(adv), .din(s1_dbl), .dout(s3_rnd)
  );
  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
      c3 <= '0;
    end else if (adv) begin
      c2 <= c1;
      c3 <= c2;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dbl <= s1_dbl; s3_dbl <= s2_dbl;
      s2_lo <= s1_lo; s3_lo <= s2_lo;
      s2_hi <= s1_hi; s3_hi <= s2_hi;
    end
  end

  // stage 4: back to extended and select
  logic [79:0] x;
  logic [63:0] rl;
  logic [15:0] rh;
  always_comb begin
    x = dbl_to_ext((c3.mode == PC_SINGLE) ? s3_rnd : s3_dbl);
    rl = 64'd0;
    rh = 16'd0;
    case (c3.op)
      OP_X2D: rl = s3_dbl;
      OP_D2X: begin
        x = dbl_to_ext(s3_dbl);
        rl = x[63:0];
        rh = x[79:64];
      end
      OP_PC: begin
        if (c3.mode == PC_EXT) begin
          rl = s3_lo;
          rh = s3_hi;
        end else begin
          rl = x[63:0];
          rh = x[79:64];
        end
      end
      default: begin
        rl = 64'd0;
        rh = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) c4 <= '0;
    else if (adv) c4 <= c3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      result_low <= rl;
      result_high <= rh;
    end
  end
endmodule
